/* rtl/dksi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dksi_pkg: shared types and codes for the dual key sorted index
// Pair type, chain control group, operation and status codes.
// ----------------------------------------------------------------------------
package dksi_pkg;

    // One stored pair
    typedef struct packed {
        logic signed [31:0] num;
        logic signed [7:0]  ch;
    } t_pair;

    // Per-chain control for one cycle
    typedef struct packed {
        logic ins;   // place the new pair
        logic rot;   // rotate the stored pairs one place towards the head
    } t_chain_ctl;

    // Operation codes
    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_DUMP_NUM  = 2'd1;
    localparam logic [1:0] OP_DUMP_CHAR = 2'd2;

    // Status codes
    localparam logic [1:0] ST_DATA    = 2'd0;
    localparam logic [1:0] ST_INS_OK  = 2'd1;
    localparam logic [1:0] ST_INS_FULL = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

endpackage

/* rtl/dksi_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dksi_cell: one position of a sorted chain
// Holds one pair; on insert it keeps, takes the new pair or takes its left
// neighbour; on rotate it takes the pair chosen by the chain.
// ----------------------------------------------------------------------------
module dksi_cell
    import dksi_pkg::*;
#(
    parameter bit BY_NUMBER = 1'b1
) (
    input  logic       i_clk,
    input  t_chain_ctl i_ctl,
    input  logic       i_valid,     // this position holds a stored pair
    input  t_pair      i_new,       // pair being inserted
    input  t_pair      i_left,      // left neighbour's pair
    input  logic       i_left_ge,   // new pair sorts at or before the left neighbour, so this cell shifts
    input  t_pair      i_rot_src,   // source on rotate
    output logic       o_ge,
    output t_pair      o_pair
);

    t_pair r_pair;
    t_pair n_pair;
    logic  w_le;

    // New key sorts at or before the stored key
    assign w_le = BY_NUMBER ? (i_new.num <= r_pair.num) : (i_new.ch <= r_pair.ch);
    assign o_ge = !i_valid || w_le;

    // Next pair
    always_comb begin
        n_pair = r_pair;
        if (i_ctl.ins) begin
            if (i_left_ge) begin
                n_pair = i_left;
            end else if (o_ge) begin
                n_pair = i_new;
            end
        end else if (i_ctl.rot) begin
            n_pair = i_rot_src;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pair <= n_pair;
    end

    assign o_pair = r_pair;

endmodule

/* rtl/dksi_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dksi_chain: a row of sorted cells for one key
// Wires the cells as neighbours; the head is cell 0 and feeds the tail of
// the stored run back during a rotation.
// ----------------------------------------------------------------------------
module dksi_chain
    import dksi_pkg::*;
#(
    parameter int CAPACITY  = 32,
    parameter bit BY_NUMBER = 1'b1,
    parameter int FW        = $clog2(CAPACITY + 1)
) (
    input  logic          i_clk,
    input  t_chain_ctl    i_ctl,
    input  logic [FW-1:0] i_fill,
    input  t_pair         i_new,
    output t_pair         o_head
);

    t_pair w_pair [CAPACITY];
    logic  w_ge   [CAPACITY];

    assign o_head = w_pair[0];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_pair w_left;
        logic  w_left_ge;
        t_pair w_right;
        t_pair w_rot_src;
        logic  w_valid;
        logic  w_tail;

        if (g == 0) begin : g_first
            assign w_left    = '0;
            assign w_left_ge = 1'b0;
        end else begin : g_mid
            assign w_left    = w_pair[g-1];
            assign w_left_ge = w_ge[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_pair[0];
        end else begin : g_inner
            assign w_right = w_pair[g+1];
        end

        // Occupancy and last stored position
        assign w_valid   = FW'(g) < i_fill;
        assign w_tail    = FW'(g + 1) == i_fill;
        assign w_rot_src = w_tail ? w_pair[0] : w_right;

        dksi_cell #(
            .BY_NUMBER (BY_NUMBER)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (i_ctl),
            .i_valid   (w_valid),
            .i_new     (i_new),
            .i_left    (w_left),
            .i_left_ge (w_left_ge),
            .i_rot_src (w_rot_src),
            .o_ge      (w_ge[g]),
            .o_pair    (w_pair[g])
        );
    end

endmodule

/* rtl/dual_key_sorted_index_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_key_sorted_index_unit: pairs kept sorted by number and by character
// Top level: two cell chains, fill count, dump sequencer, output register.
// ----------------------------------------------------------------------------
// On an insert every cell of both chains compares the new key with its own
// and shifts or loads in the same edge, and the status beat goes to the
// output register, so inserts can arrive back to back while the output is
// not stalled. A dump of a non-empty store gives one beat per stored pair
// from the head of the chosen chain, which rotates one place per beat and
// leaves the chain as it was after the last beat; no new beat is taken on
// the input while a dump runs. A dump of an empty store answers in its
// accept cycle. Operation code 3 is consumed with no result. An insert
// into a full store is dropped with the full status.
module dual_key_sorted_index_unit
    import dksi_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_operation,
    input  logic signed [31:0] i_key_number,
    input  logic signed [7:0]  i_key_char,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_out_number,
    output logic signed [7:0]  o_out_char,
    output logic               o_last_item,
    output logic [1:0]         o_status
);

    localparam int FW = $clog2(CAPACITY + 1);

    logic [FW-1:0] r_fill, n_fill;
    logic          r_busy, n_busy;
    logic          r_sel_char, n_sel_char;
    logic [FW-1:0] r_cnt, n_cnt;
    logic          r_out_valid;
    t_pair         r_out_pair;
    logic          r_out_last;
    logic [1:0]    r_out_status;

    logic       w_out_free;
    logic       w_in_acc;
    logic       w_emit;
    t_pair      w_emit_pair;
    logic       w_emit_last;
    logic [1:0] w_emit_status;
    t_chain_ctl w_ctl_num, w_ctl_char;
    t_pair      w_new, w_head_num, w_head_char;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_busy || !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_new      = '{num: i_key_number, ch: i_key_char};

    // Control: inserts, dump start and dump beats
    always_comb begin
        n_fill        = r_fill;
        n_busy        = r_busy;
        n_sel_char    = r_sel_char;
        n_cnt         = r_cnt;
        w_emit        = 1'b0;
        w_emit_pair   = '0;
        w_emit_last   = 1'b1;
        w_emit_status = ST_DATA;
        w_ctl_num     = '0;
        w_ctl_char    = '0;

        if (r_busy) begin
            if (w_out_free) begin
                w_emit      = 1'b1;
                w_emit_pair = r_sel_char ? w_head_char : w_head_num;
                w_emit_last = (r_cnt + 1'b1) == r_fill;
                n_cnt       = r_cnt + 1'b1;
                if (w_emit_last) begin
                    n_busy = 1'b0;
                end
                if (r_sel_char) begin
                    w_ctl_char.rot = 1'b1;
                end else begin
                    w_ctl_num.rot = 1'b1;
                end
            end
        end else if (w_in_acc) begin
            case (i_operation)
                OP_INSERT: begin
                    w_emit = 1'b1;
                    if (r_fill == FW'(CAPACITY)) begin
                        w_emit_status = ST_INS_FULL;
                    end else begin
                        w_emit_status  = ST_INS_OK;
                        w_ctl_num.ins  = 1'b1;
                        w_ctl_char.ins = 1'b1;
                        n_fill         = r_fill + 1'b1;
                    end
                end
                OP_DUMP_NUM, OP_DUMP_CHAR: begin
                    if (r_fill == '0) begin
                        w_emit        = 1'b1;
                        w_emit_status = ST_EMPTY;
                    end else begin
                        n_busy     = 1'b1;
                        n_sel_char = (i_operation == OP_DUMP_CHAR);
                        n_cnt      = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_busy      <= 1'b0;
            r_sel_char  <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill     <= n_fill;
            r_busy     <= n_busy;
            r_sel_char <= n_sel_char;
            r_cnt      <= n_cnt;
            if (w_out_free) begin
                r_out_valid <= w_emit;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_out_free && w_emit) begin
            r_out_pair   <= w_emit_pair;
            r_out_last   <= w_emit_last;
            r_out_status <= w_emit_status;
        end
    end

    dksi_chain #(
        .CAPACITY  (CAPACITY),
        .BY_NUMBER (1'b1),
        .FW        (FW)
    ) u_chain_num (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl_num),
        .i_fill (r_fill),
        .i_new  (w_new),
        .o_head (w_head_num)
    );

    dksi_chain #(
        .CAPACITY  (CAPACITY),
        .BY_NUMBER (1'b0),
        .FW        (FW)
    ) u_chain_char (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl_char),
        .i_fill (r_fill),
        .i_new  (w_new),
        .o_head (w_head_char)
    );

    assign o_out_valid  = r_out_valid;
    assign o_out_number = r_out_pair.num;
    assign o_out_char   = r_out_pair.ch;
    assign o_last_item  = r_out_last;
    assign o_status     = r_out_status;

endmodule
